// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the spatializer unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSP_ASSERT_NEVER(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define SSP_ASSERT(name, prop, msg)
`define SSP_ASSERT_NEVER(name, prop, msg)
`endif
`endif

// ----- rtl/ssp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo spatializer package
// Widths, item types and register codes shared by the spatializer modules.
// ---------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned VOICES = 512;
  localparam int unsigned VA_W   = $clog2(VOICES);

  localparam int unsigned VOICE_W = 9;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned VOL_W   = 16;
  localparam int unsigned DM_W    = 20;
  localparam int unsigned PH_W    = 8;
  localparam int unsigned CFG_W   = 24;

  localparam int unsigned D_W     = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * D_W;
  localparam int unsigned SQR_W   = SQ_W + 1;
  localparam int unsigned LEN_W   = D_W;
  localparam int unsigned SQRT_N  = LEN_W;
  localparam int unsigned NUM_W   = D_W + REG_W + 2;
  localparam int unsigned Q_W     = 18;
  localparam int unsigned DOT_W   = Q_W + 1;
  localparam int unsigned PM_W    = LEN_W + DM_W;
  localparam int unsigned PM_SH   = 16;
  localparam int unsigned ATT_W   = 31;
  localparam int unsigned DS_W    = DOT_W + REG_W;
  localparam int unsigned S_W     = DS_W + 1;
  localparam int unsigned SPLIT   = S_W / 2;
  localparam int unsigned P_W     = ATT_W + SPLIT + 1;
  localparam int unsigned PR_W    = P_W + SPLIT;
  localparam int unsigned T_LSB   = 28;
  localparam int unsigned T_W     = 32;
  localparam int unsigned G_W     = VOL_W + T_W;
  localparam int unsigned PH_SH   = 22;
  localparam int unsigned PHW     = DS_W - PH_SH;

  localparam logic signed [ATT_W-1:0] ATT_ONE = ATT_W'(65536);
  localparam logic signed [S_W-1:0]   S_ONE   = S_W'(1) << T_LSB;
  localparam int PH_MAX = 127;
  localparam int PH_MIN = -128;

  typedef enum logic [2:0] {
    CFG_LX, CFG_LY, CFG_LZ, CFG_RX, CFG_RY, CFG_RZ, CFG_SEP, CFG_PHS
  } cfg_idx_e;

  typedef struct packed {
    logic [VOICE_W-1:0]        voice;
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] src_z;
    logic [VOL_W-1:0]          base_volume;
    logic [DM_W-1:0]           atten_rate;
    logic                      from_view;
  } ssp_in_t;

  typedef struct packed {
    logic [VOL_W-1:0]       left_gain;
    logic [VOL_W-1:0]       right_gain;
    logic signed [PH_W-1:0] phase_samples;
    logic signed [PH_W-1:0] prev_phase;
  } ssp_out_t;

  typedef struct packed {
    logic [VA_W-1:0]  addr;
    logic             ok;
    logic [VOL_W-1:0] vol;
    logic             view;
  } vinfo_t;

  typedef struct packed {
    vinfo_t                  info;
    logic [DM_W-1:0]         dm;
    logic signed [NUM_W-1:0] num;
  } sq_side_t;

  typedef struct packed {
    vinfo_t                  info;
    logic signed [ATT_W-1:0] att;
  } dv_side_t;

endpackage

// ----- rtl/ssp_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module ssp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ssp_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor of the root, side data carried along.
// ---------------------------------------------------------------------------
module ssp_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ssp_pkg::SQ_W-1:0] x_i,
  input  ssp_pkg::sq_side_t        side_i,
  output logic                     valid_o,
  output logic [ssp_pkg::LEN_W-1:0] len_o,
  output ssp_pkg::sq_side_t        side_o
);
  import ssp_pkg::*;

  logic [SQ_W-1:0]  x_q    [SQRT_N];
  logic [SQR_W-1:0] r_q    [SQRT_N];
  sq_side_t         side_q [SQRT_N];
  logic             v_q    [SQRT_N];

  for (genvar k = 0; k < SQRT_N; k++) begin : g_st
    localparam logic [SQR_W-1:0] BIT = SQR_W'(1) << (2 * (SQRT_N - 1 - k));
    logic [SQ_W-1:0]  x_in;
    logic [SQR_W-1:0] r_in;
    logic [SQR_W-1:0] trial;
    sq_side_t         s_in;
    logic             v_in;

    if (k == 0) begin : g_first
      assign x_in = x_i;
      assign r_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, x_in} >= trial) begin
          x_q[k] <= x_in - trial[SQ_W-1:0];
          r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          x_q[k] <= x_in;
          r_q[k] <= r_in >> 1;
        end
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[SQRT_N-1];
  assign len_o   = r_q[SQRT_N-1][LEN_W-1:0];
  assign side_o  = side_q[SQRT_N-1];

endmodule

// ----- rtl/ssp_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined signed divider
// Magnitude stage, then one restoring quotient bit per stage; the quotient
// is truncated toward zero and forced to zero for a zero divisor.
// ---------------------------------------------------------------------------
module ssp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [ssp_pkg::NUM_W-1:0] num_i,
  input  logic [ssp_pkg::LEN_W-1:0]        len_i,
  input  ssp_pkg::dv_side_t                side_i,
  output logic                             valid_o,
  output logic signed [ssp_pkg::DOT_W-1:0] dot_o,
  output ssp_pkg::dv_side_t                side_o
);
  import ssp_pkg::*;

  logic [NUM_W-1:0] a_mag_q;
  logic [LEN_W-1:0] a_len_q;
  logic             a_neg_q;
  dv_side_t         a_side_q;
  logic             a_v_q;

  logic [NUM_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  logic [LEN_W-1:0] len_q  [Q_W];
  logic             neg_q  [Q_W];
  dv_side_t         side_q [Q_W];
  logic             v_q    [Q_W];

  logic signed [DOT_W-1:0] qs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q  <= num_i[NUM_W-1] ? $unsigned(-num_i) : $unsigned(num_i);
      a_neg_q  <= num_i[NUM_W-1];
      a_len_q  <= len_i;
      a_side_q <= side_i;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int unsigned SH = Q_W - 1 - k;
    logic [NUM_W-1:0] r_in;
    logic [NUM_W-1:0] dsh;
    logic [Q_W-1:0]   q_in;
    logic [LEN_W-1:0] l_in;
    logic             n_in;
    dv_side_t         s_in;
    logic             v_in;

    if (k == 0) begin : g_first
      assign r_in = a_mag_q;
      assign q_in = '0;
      assign l_in = a_len_q;
      assign n_in = a_neg_q;
      assign s_in = a_side_q;
      assign v_in = a_v_q;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign l_in = len_q[k-1];
      assign n_in = neg_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign dsh = NUM_W'(l_in) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_in >= dsh) begin
          rem_q[k] <= r_in - dsh;
          quo_q[k] <= q_in | (Q_W'(1) << SH);
        end else begin
          rem_q[k] <= r_in;
          quo_q[k] <= q_in;
        end
        len_q[k]  <= l_in;
        neg_q[k]  <= n_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign qs      = $signed({1'b0, quo_q[Q_W-1]});
  assign dot_o   = (len_q[Q_W-1] == '0) ? '0 : (neg_q[Q_W-1] ? -qs : qs);
  assign valid_o = v_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// ----- rtl/stereo_spatializer_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo spatializer unit
// Per-voice stereo gains and interaural phase with a per-voice phase memory.
// ---------------------------------------------------------------------------
// The unit takes one item per clock unless the full output buffer stalls it,
// and returns results in order; the distance and pan path runs through the
// 25-stage square root and the 19-stage divider. A two-entry output buffer
// lets the pipeline keep moving while one result waits to be taken. After
// reset the voice phase memory is cleared, one entry per cycle, during which
// no item is accepted; configuration writes are taken at any time.
module stereo_spatializer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ssp_pkg::ssp_in_t           in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ssp_pkg::ssp_out_t          out_item_o,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [ssp_pkg::CFG_W-1:0]  cfg_data_i
);
  import ssp_pkg::*;
`include "assert_macros.svh"

  logic signed [COORD_W-1:0] lx_q, ly_q, lz_q;
  logic signed [REG_W-1:0]   rx_q, ry_q, rz_q, sep_q, phs_q;

  logic                 en;
  logic                 clr_q;
  logic [VA_W-1:0]      clr_addr_q;

  logic                    s1_v_q;
  vinfo_t                  s1_info_q;
  logic [DM_W-1:0]         s1_dm_q;
  logic signed [D_W-1:0]   s1_dx_q, s1_dy_q, s1_dz_q;

  logic                    s2_v_q;
  vinfo_t                  s2_info_q;
  logic [DM_W-1:0]         s2_dm_q;
  logic [SQ_W-1:0]         s2_sqx_q, s2_sqy_q, s2_sqz_q;
  logic signed [NUM_W-1:0] s2_px_q, s2_py_q, s2_pz_q;

  logic                    s3_v_q;
  logic [SQ_W-1:0]         s3_sq_q;
  sq_side_t                s3_side_q;

  logic                    sq_v;
  logic [LEN_W-1:0]        sq_len;
  sq_side_t                sq_side;

  logic                    s4_v_q;
  vinfo_t                  s4_info_q;
  logic [LEN_W-1:0]        s4_len_q;
  logic [PM_W-1:0]         s4_pm_q;
  logic signed [NUM_W-1:0] s4_num_q;
  dv_side_t                dv_in;

  logic                    dv_v;
  logic signed [DOT_W-1:0] dv_dot;
  dv_side_t                dv_side;

  logic                    s5_v_q;
  vinfo_t                  s5_info_q;
  logic signed [DOT_W-1:0] s5_dot_q;
  logic signed [ATT_W-1:0] s5_att_q;

  logic                    s6_v_q;
  vinfo_t                  s6_info_q;
  logic signed [DS_W-1:0]  s6_ds_q, s6_php_q;
  logic signed [ATT_W-1:0] s6_att_q;

  logic                    s7_v_q;
  vinfo_t                  s7_info_q;
  logic signed [S_W-1:0]   s7_sl_q, s7_sr_q;
  logic signed [ATT_W-1:0] s7_att_q;
  logic signed [PH_W-1:0]  s7_ph_q;
  logic signed [DS_W-1:0]  php_rnd;
  logic signed [PHW-1:0]   php_w;
  logic signed [PH_W-1:0]  ph_d;

  logic                    s8_v_q;
  vinfo_t                  s8_info_q;
  logic signed [P_W-1:0]   s8_ll_q, s8_lh_q, s8_rl_q, s8_rh_q;
  logic signed [PH_W-1:0]  s8_ph_q;

  logic signed [PR_W-1:0]  prod_l, prod_r;
  logic                    s9_v_q;
  vinfo_t                  s9_info_q;
  logic [T_W-1:0]          s9_tl_q, s9_tr_q;
  logic                    s9_satl_q, s9_satr_q, s9_posl_q, s9_posr_q;
  logic signed [PH_W-1:0]  s9_ph_q;

  logic                    s10_v_q;
  vinfo_t                  s10_info_q;
  logic [G_W-1:0]          s10_gl_q, s10_gr_q;
  logic                    s10_satl_q, s10_satr_q, s10_posl_q, s10_posr_q;
  logic signed [PH_W-1:0]  s10_ph_q;
  logic                    s10_fwd_q;
  logic signed [PH_W-1:0]  s10_fwdv_q;

  logic                    ram_we;
  logic [VA_W-1:0]         ram_waddr;
  logic [PH_W-1:0]         ram_wdata;
  logic [PH_W-1:0]         ram_rdata;

  ssp_out_t                res;
  ssp_out_t                fifo_q [2];
  logic                    wr_ptr_q, rd_ptr_q;
  logic [1:0]              cnt_q;
  logic                    fifo_full, push, pop;

  function automatic logic [VOL_W-1:0] gain_f(input logic [VOL_W-1:0] vol,
                                              input logic view, input logic pos,
                                              input logic sat, input logic [G_W-1:0] g);
    logic [VOL_W-1:0] r;
    if (view) begin
      r = vol;
    end else if (!pos || vol == '0) begin
      r = '0;
    end else if (sat || (g[G_W-1:2*VOL_W] != '0)) begin
      r = '1;
    end else begin
      r = g[2*VOL_W-1:VOL_W];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q  <= '0;
      ly_q  <= '0;
      lz_q  <= '0;
      rx_q  <= '0;
      ry_q  <= -REG_W'(16384);
      rz_q  <= '0;
      sep_q <= REG_W'(16384);
      phs_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LX:  lx_q  <= $signed(cfg_data_i[COORD_W-1:0]);
        CFG_LY:  ly_q  <= $signed(cfg_data_i[COORD_W-1:0]);
        CFG_LZ:  lz_q  <= $signed(cfg_data_i[COORD_W-1:0]);
        CFG_RX:  rx_q  <= $signed(cfg_data_i[REG_W-1:0]);
        CFG_RY:  ry_q  <= $signed(cfg_data_i[REG_W-1:0]);
        CFG_RZ:  rz_q  <= $signed(cfg_data_i[REG_W-1:0]);
        CFG_SEP: sep_q <= $signed(cfg_data_i[REG_W-1:0]);
        CFG_PHS: phs_q <= $signed(cfg_data_i[REG_W-1:0]);
        default: ;
      endcase
    end
  end

  // Memory clear after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + VA_W'(1);
      if (clr_addr_q == VA_W'(VOICES - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign fifo_full  = (cnt_q == 2'd2);
  assign en         = !(fifo_full && s10_v_q);
  assign in_ready_o = en && !clr_q;

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      s9_v_q  <= 1'b0;
      s10_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i && in_ready_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= sq_v;
      s5_v_q  <= dv_v;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      s8_v_q  <= s7_v_q;
      s9_v_q  <= s8_v_q;
      s10_v_q <= s9_v_q;
    end
  end

  // Front: differences, products, sums.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_info_q.addr <= VA_W'(in_item_i.voice);
      s1_info_q.ok   <= (32'(in_item_i.voice) < VOICES);
      s1_info_q.vol  <= in_item_i.base_volume;
      s1_info_q.view <= in_item_i.from_view;
      s1_dm_q        <= in_item_i.atten_rate;
      s1_dx_q        <= D_W'(in_item_i.src_x) - D_W'(lx_q);
      s1_dy_q        <= D_W'(in_item_i.src_y) - D_W'(ly_q);
      s1_dz_q        <= D_W'(in_item_i.src_z) - D_W'(lz_q);

      s2_info_q <= s1_info_q;
      s2_dm_q   <= s1_dm_q;
      s2_sqx_q  <= $unsigned(SQ_W'(s1_dx_q) * SQ_W'(s1_dx_q));
      s2_sqy_q  <= $unsigned(SQ_W'(s1_dy_q) * SQ_W'(s1_dy_q));
      s2_sqz_q  <= $unsigned(SQ_W'(s1_dz_q) * SQ_W'(s1_dz_q));
      s2_px_q   <= NUM_W'(s1_dx_q) * NUM_W'(rx_q);
      s2_py_q   <= NUM_W'(s1_dy_q) * NUM_W'(ry_q);
      s2_pz_q   <= NUM_W'(s1_dz_q) * NUM_W'(rz_q);

      s3_sq_q        <= s2_sqx_q + s2_sqy_q + s2_sqz_q;
      s3_side_q.info <= s2_info_q;
      s3_side_q.dm   <= s2_dm_q;
      s3_side_q.num  <= s2_px_q + s2_py_q + s2_pz_q;
    end
  end

  ssp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .x_i     (s3_sq_q),
    .side_i  (s3_side_q),
    .valid_o (sq_v),
    .len_o   (sq_len),
    .side_o  (sq_side)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_info_q <= sq_side.info;
      s4_len_q  <= sq_len;
      s4_pm_q   <= PM_W'(sq_len) * PM_W'(sq_side.dm);
      s4_num_q  <= sq_side.num;
    end
  end

  assign dv_in.info = s4_info_q;
  assign dv_in.att  = ATT_ONE - $signed(ATT_W'(s4_pm_q[PM_W-1:PM_SH]));

  ssp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_i   (s4_num_q),
    .len_i   (s4_len_q),
    .side_i  (dv_in),
    .valid_o (dv_v),
    .dot_o   (dv_dot),
    .side_o  (dv_side)
  );

  // Phase: scale times dot over 2^22, truncated toward zero, saturated; zero for view items.
  always_comb begin
    php_rnd = s6_php_q + (s6_php_q[DS_W-1] ? DS_W'((1 << PH_SH) - 1) : '0);
    php_w   = php_rnd[DS_W-1:PH_SH];
    if (s6_info_q.view) begin
      ph_d = '0;
    end else if (php_w > PH_MAX) begin
      ph_d = PH_W'(PH_MAX);
    end else if (php_w < PH_MIN) begin
      ph_d = PH_W'(PH_MIN);
    end else begin
      ph_d = php_w[PH_W-1:0];
    end
  end

  assign prod_l = (PR_W'(s8_lh_q) <<< SPLIT) + PR_W'(s8_ll_q);
  assign prod_r = (PR_W'(s8_rh_q) <<< SPLIT) + PR_W'(s8_rl_q);

  // Back: pan scale, attenuation product, gains.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_info_q <= dv_side.info;
      s5_att_q  <= dv_side.att;
      s5_dot_q  <= dv_dot;

      s6_info_q <= s5_info_q;
      s6_att_q  <= s5_att_q;
      s6_ds_q   <= DS_W'(s5_dot_q) * DS_W'(sep_q);
      s6_php_q  <= DS_W'(s5_dot_q) * DS_W'(phs_q);

      s7_info_q <= s6_info_q;
      s7_att_q  <= s6_att_q;
      s7_sl_q   <= S_ONE - S_W'(s6_ds_q);
      s7_sr_q   <= S_ONE + S_W'(s6_ds_q);
      s7_ph_q   <= ph_d;

      s8_info_q <= s7_info_q;
      s8_ph_q   <= s7_ph_q;
      s8_ll_q   <= P_W'(s7_att_q) * P_W'($signed({1'b0, s7_sl_q[SPLIT-1:0]}));
      s8_lh_q   <= P_W'(s7_att_q) * P_W'($signed(s7_sl_q[S_W-1:SPLIT]));
      s8_rl_q   <= P_W'(s7_att_q) * P_W'($signed({1'b0, s7_sr_q[SPLIT-1:0]}));
      s8_rh_q   <= P_W'(s7_att_q) * P_W'($signed(s7_sr_q[S_W-1:SPLIT]));

      s9_info_q <= s8_info_q;
      s9_ph_q   <= s8_ph_q;
      s9_posl_q <= !prod_l[PR_W-1];
      s9_posr_q <= !prod_r[PR_W-1];
      s9_satl_q <= |prod_l[PR_W-1:T_LSB+T_W];
      s9_satr_q <= |prod_r[PR_W-1:T_LSB+T_W];
      s9_tl_q   <= prod_l[T_LSB+T_W-1:T_LSB];
      s9_tr_q   <= prod_r[T_LSB+T_W-1:T_LSB];

      s10_info_q <= s9_info_q;
      s10_ph_q   <= s9_ph_q;
      s10_posl_q <= s9_posl_q;
      s10_posr_q <= s9_posr_q;
      s10_satl_q <= s9_satl_q;
      s10_satr_q <= s9_satr_q;
      s10_gl_q   <= G_W'(s9_info_q.vol) * G_W'(s9_tl_q);
      s10_gr_q   <= G_W'(s9_info_q.vol) * G_W'(s9_tr_q);
      s10_fwd_q  <= s10_v_q && s10_info_q.ok && s9_info_q.ok &&
                    (s10_info_q.addr == s9_info_q.addr);
      s10_fwdv_q <= s10_ph_q;
    end
  end

  // Voice phase memory: read as an item enters the last stage, written as it leaves.
  assign ram_we    = clr_q || (en && s10_v_q && s10_info_q.ok);
  assign ram_waddr = clr_q ? clr_addr_q : s10_info_q.addr;
  assign ram_wdata = clr_q ? '0 : s10_ph_q;

  ssp_ram #(
    .WIDTH (PH_W),
    .DEPTH (VOICES)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (en),
    .raddr_i (s9_info_q.addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res.left_gain  = gain_f(s10_info_q.vol, s10_info_q.view, s10_posl_q, s10_satl_q,
                            s10_gl_q);
    res.right_gain = gain_f(s10_info_q.vol, s10_info_q.view, s10_posr_q, s10_satr_q,
                            s10_gr_q);
    res.phase_samples = s10_ph_q;
    if (!s10_info_q.ok) begin
      res.prev_phase = '0;
    end else if (s10_fwd_q) begin
      res.prev_phase = s10_fwdv_q;
    end else begin
      res.prev_phase = $signed(ram_rdata);
    end
  end

  // Output buffer.
  assign push        = en && s10_v_q;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  `SSP_ASSERT(a_clear_blocks_input, clr_q |-> !in_ready_o, "item accepted during memory clear")
  `SSP_ASSERT(a_clear_pipe_empty, clr_q |-> !s10_v_q, "pipeline busy during memory clear")
  `SSP_ASSERT_NEVER(a_fifo_overflow, push && fifo_full, "output buffer overflow")

endmodule

// ----- bench/stereo_spatializer_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo spatializer unit testbench
// Drives voice updates through the unit under several listener settings and
// checks every gain, phase and stored phase against an in-bench computation.
// ---------------------------------------------------------------------------
module stereo_spatializer_unit_tb;
  import ssp_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ssp_in_t           in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ssp_out_t          out_item;
  logic              cfg_we = 1'b0;
  cfg_idx_e          cfg_idx = CFG_LX;
  logic [CFG_W-1:0]  cfg_data = '0;

  longint            lis_pos [3];
  longint            right_vec [3];
  longint            sep_q14;
  longint            phase_q8;
  logic signed [7:0] phase_mem [VOICES];

  ssp_out_t          pending_gains [$];
  int unsigned       mismatches = 0;
  int unsigned       voices_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       view_hits = 0;
  int unsigned       clipped_gains = 0;
  bit                calm = 1'b0;

  stereo_spatializer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("stereo_spatializer_unit_tb NOT OK");
    $finish;
  end

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint trunc_shift(input longint v, input int sh);
    if (v < 0) return -longint'(longint'(-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic logic [15:0] gain_of(input longint vol, input longint att,
                                          input longint scale);
    longint t;
    longint g;
    t = trunc_shift(att * scale, 28);
    g = vol * t;
    if (g <= 0) return 16'd0;
    if ((g >>> 16) > 65535) return 16'hFFFF;
    return 16'(g >>> 16);
  endfunction

  function automatic ssp_out_t predict_voice(input ssp_in_t it);
    longint          dx, dy, dz, att, dotv, ds, phv, vol;
    longint unsigned sq, len, dm;
    ssp_out_t        r;
    dx = longint'($signed(it.src_x)) - lis_pos[0];
    dy = longint'($signed(it.src_y)) - lis_pos[1];
    dz = longint'($signed(it.src_z)) - lis_pos[2];
    vol = longint'(it.base_volume);
    dm = longint'(it.atten_rate);
    if (it.from_view) begin
      r.left_gain = it.base_volume;
      r.right_gain = it.base_volume;
      phv = 0;
    end else begin
      sq = dx * dx + dy * dy + dz * dz;
      len = isqrt(sq);
      att = 65536 - longint'((len * dm) >> 16);
      dotv = 0;
      if (len != 0)
        dotv = (dx * right_vec[0] + dy * right_vec[1] + dz * right_vec[2]) / longint'(len);
      ds = dotv * sep_q14;
      r.left_gain = gain_of(vol, att, (longint'(1) << 28) - ds);
      r.right_gain = gain_of(vol, att, (longint'(1) << 28) + ds);
      phv = trunc_shift(phase_q8 * dotv, 22);
      if (phv > PH_MAX) phv = PH_MAX;
      if (phv < PH_MIN) phv = PH_MIN;
    end
    r.phase_samples = 8'(phv);
    r.prev_phase = phase_mem[it.voice];
    phase_mem[it.voice] = 8'(phv);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
  endtask

  always @(posedge clk_i) begin
    ssp_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_gains.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_gains.pop_front();
        if (out_item.left_gain !== want.left_gain)
          report_mismatch("left_gain", out_item.left_gain, want.left_gain);
        if (out_item.right_gain !== want.right_gain)
          report_mismatch("right_gain", out_item.right_gain, want.right_gain);
        if (out_item.phase_samples !== want.phase_samples)
          report_mismatch("phase_samples", $signed(out_item.phase_samples),
                          $signed(want.phase_samples));
        if (out_item.prev_phase !== want.prev_phase)
          report_mismatch("prev_phase", $signed(out_item.prev_phase),
                          $signed(want.prev_phase));
        if (want.left_gain == 16'hFFFF || want.right_gain == 16'hFFFF) clipped_gains++;
      end
      results_seen++;
    end
  end

  always @(negedge clk_i) begin
    out_ready = calm || ($urandom_range(99) >= 9);
  end

  task automatic send_voice(input ssp_in_t it);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk_i); while (!in_ready);
    pending_gains.push_back(predict_voice(it));
    voices_sent++;
    if (it.from_view) view_hits++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_gains.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input longint value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = CFG_W'(value);
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_LX:  lis_pos[0] = longint'($signed(24'(value)));
      CFG_LY:  lis_pos[1] = longint'($signed(24'(value)));
      CFG_LZ:  lis_pos[2] = longint'($signed(24'(value)));
      CFG_RX:  right_vec[0] = longint'($signed(16'(value)));
      CFG_RY:  right_vec[1] = longint'($signed(16'(value)));
      CFG_RZ:  right_vec[2] = longint'($signed(16'(value)));
      CFG_SEP: sep_q14 = longint'($signed(16'(value)));
      default: phase_q8 = longint'($signed(16'(value)));
    endcase
  endtask

  task automatic set_listener(input longint x, input longint y, input longint z,
                              input longint rx, input longint ry, input longint rz,
                              input longint sep, input longint phs);
    wait_drained();
    write_reg(CFG_LX, x);
    write_reg(CFG_LY, y);
    write_reg(CFG_LZ, z);
    write_reg(CFG_RX, rx);
    write_reg(CFG_RY, ry);
    write_reg(CFG_RZ, rz);
    write_reg(CFG_SEP, sep);
    write_reg(CFG_PHS, phs);
  endtask

  function automatic ssp_in_t voice_at(input int v, input longint x, input longint y,
                                       input longint z, input int vol, input int dm,
                                       input bit view);
    ssp_in_t it;
    it.voice = VOICE_W'(v);
    it.src_x = COORD_W'(x);
    it.src_y = COORD_W'(y);
    it.src_z = COORD_W'(z);
    it.base_volume = VOL_W'(vol);
    it.atten_rate = DM_W'(dm);
    it.from_view = view;
    return it;
  endfunction

  function automatic ssp_in_t random_voice();
    ssp_in_t it;
    int      spread;
    it.voice = VOICE_W'($urandom);
    it.base_volume = VOL_W'($urandom);
    it.from_view = ($urandom_range(99) < 8);
    if ($urandom_range(99) < 15) begin
      it.src_x = COORD_W'($urandom);
      it.src_y = COORD_W'($urandom);
      it.src_z = COORD_W'($urandom);
      it.atten_rate = DM_W'($urandom);
    end else begin
      spread = $urandom_range(22, 2);
      it.src_x = COORD_W'(lis_pos[0] + ($signed($urandom) >>> (32 - spread)));
      it.src_y = COORD_W'(lis_pos[1] + ($signed($urandom) >>> (32 - spread)));
      it.src_z = COORD_W'(lis_pos[2] + ($signed($urandom) >>> (32 - spread)));
      it.atten_rate = DM_W'($urandom) >> $urandom_range(20, 0);
    end
    return it;
  endfunction

  task automatic test_reset_defaults();
    send_voice(voice_at(0, 0, 0, 0, 32768, 0, 0));
    send_voice(voice_at(511, 2560, 0, 0, 65535, 0, 0));
    send_voice(voice_at(1, 0, -2560, 0, 65535, 4096, 0));
    send_voice(voice_at(2, 0, 2560, 0, 0, 100, 0));
  endtask

  task automatic test_directed_extremes();
    set_listener(1000, -2000, 300, 16384, 0, 0, -32768, 32767);
    send_voice(voice_at(3, 1000, -2000, 300, 40000, 1000, 0));
    send_voice(voice_at(3, 8388607, -2000, 300, 65535, 0, 0));
    send_voice(voice_at(3, -8388608, -2000, 300, 65535, 0, 0));
    send_voice(voice_at(4, 8388607, 8388607, 8388607, 65535, 1048575, 0));
    send_voice(voice_at(4, -8388608, -8388608, -8388608, 0, 1048575, 0));
    send_voice(voice_at(5, 5000, 0, 0, 65535, 0, 1));
    send_voice(voice_at(5, -5000, 0, 0, 65535, 0, 0));
    set_listener(-8388608, 8388607, 0, -16384, 16384, 16384, 32767, -32768);
    send_voice(voice_at(6, -8380000, 8388607, 0, 65535, 1048575, 0));
    send_voice(voice_at(6, 8388607, -8388608, 0, 65535, 1048575, 0));
    send_voice(voice_at(7, -8388608, 8388607, 0, 65535, 12, 0));
    send_voice(voice_at(7, -8388000, 8388000, 500, 30000, 300, 0));
    send_voice(voice_at(511, 0, 0, 0, 65535, 0, 1));
    set_listener(8388607, 0, -8388608, 0, 0, -16384, 0, 0);
    send_voice(voice_at(8, 8388000, 0, -8388608, 65535, 0, 0));
    send_voice(voice_at(8, 0, 0, 0, 65535, 4, 0));
  endtask

  task automatic test_random_sweep(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        if ($urandom_range(1)) set_listener($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                                            $signed($urandom) >>> 8,
                                            $urandom_range(32768) - 16384,
                                            $urandom_range(32768) - 16384,
                                            $urandom_range(32768) - 16384,
                                            $signed($urandom) >>> 16,
                                            $signed($urandom) >>> 16);
        else set_listener(0, 0, 0, 0, -16384, 0, 16384, 16'($urandom_range(1536)));
      end
      calm = (i < 300);
      send_voice(random_voice());
    end
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 40; i++) send_voice(random_voice());
    wait_drained();
    for (int i = 0; i < 40; i++) send_voice(random_voice());
  endtask

  initial begin
    lis_pos = '{0, 0, 0};
    right_vec = '{0, -16384, 0};
    sep_q14 = 16384;
    phase_q8 = 0;
    foreach (phase_mem[v]) phase_mem[v] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_random_sweep(1600);
    test_drain_pause();
    wait_drained();
    $display("%0d voice updates checked, %0d from the view entity, %0d saturated gains,",
             voices_sent, view_hits, clipped_gains);
    $display("over random and extreme listener positions, pan vectors and separations.");
    if (mismatches == 0 && pending_gains.size() == 0) begin
      $display("stereo_spatializer_unit_tb OK");
    end else begin
      $display("stereo_spatializer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
